### src/txcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package txcw_pkg;

  localparam int ROWS_DEF    = 25;
  localparam int COLS_DEF    = 80;
  localparam int ACTION_W    = 2;
  localparam int CHAR_W      = 8;
  localparam int ATTR_W      = 8;
  localparam int INDEX_W     = 11;
  localparam int CELL_W      = 16;
  localparam int POS_W       = 11;
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 32;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0a;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h02;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUT   = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_PUT,
    ST_READ,
    ST_SCROLL,
    ST_CLEAR,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

### src/txcw_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module txcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### src/text_console_writer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Text-mode console of ROWS x COLS cells held in one single-port-write, registered-read
// memory; each cell is attribute (high byte) and character (low byte). After reset the
// block runs a clearing pass over every cell before it takes the first transaction.
// A plain put or a read goes through its own state and ST_EMIT before its result is
// registered; an unused action goes straight to ST_EMIT. A clear sweeps the memory one
// cell a cycle. A put that moves past the last row scrolls by moving each row up a row
// through the memory's one read and one write port and blanking the last row; then a
// newline emits its result and any other character is written. Items are handled one at
// a time; the result register lets the next transaction be accepted while a result still waits on the output side.
module text_console_writer_top #(
  parameter int ROWS = txcw_pkg::ROWS_DEF,
  parameter int COLS = txcw_pkg::COLS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_wr_en,
  input  wire logic [txcw_pkg::ATTR_W-1:0]        cfg_wr_data,   // text_attribute
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [txcw_pkg::IN_DATA_W-1:0]     in_tdata,      // char_code, cell_index
  input  wire logic [txcw_pkg::ACTION_W-1:0]      in_tuser,      // action
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic      [txcw_pkg::OUT_DATA_W-1:0]    out_tdata      // cell_value, cursor_pos
);

  localparam int CELLS = ROWS * COLS;
  localparam int MOVE  = (ROWS - 1) * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int CNTW  = $clog2(CELLS + 1);
  localparam int RW    = $clog2(ROWS);
  localparam int CLW   = $clog2(COLS + 1);
  localparam int CMPW  = CNTW + txcw_pkg::INDEX_W;
  localparam int PXW   = CNTW + txcw_pkg::POS_W;
  localparam int PADW  = txcw_pkg::OUT_DATA_W - txcw_pkg::CELL_W - txcw_pkg::POS_W;

  txcw_pkg::state_t state_r, state_nxt;
  logic [CNTW-1:0]              cnt_r, cnt_nxt;
  logic [RW-1:0]                row_r, row_nxt;
  logic [CLW-1:0]               col_r, col_nxt;
  logic [txcw_pkg::ATTR_W-1:0]  attr_r;
  logic [txcw_pkg::CHAR_W-1:0]  char_r, char_nxt;
  logic                         rd_ok_r, rd_ok_nxt;
  logic [txcw_pkg::CELL_W-1:0]  value_r, value_nxt;
  logic                         out_tvalid_r, out_tvalid_nxt;
  logic [txcw_pkg::OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [txcw_pkg::CELL_W-1:0]  mem_wdata;
  logic [AW-1:0]                mem_raddr;
  logic [txcw_pkg::CELL_W-1:0]  mem_rdata;

  logic [txcw_pkg::CHAR_W-1:0]  in_char;
  logic [txcw_pkg::INDEX_W-1:0] in_index;
  logic [CMPW-1:0]              index_ext;
  logic [CNTW-1:0]              pos;
  logic [PXW-1:0]               pos_ext;
  logic [AW-1:0]                cur_addr;
  logic [CNTW-1:0]              scroll_raddr;
  logic                         at_last_row;
  logic                         out_free;

  assign in_char   = in_tdata[txcw_pkg::CHAR_W-1:0];
  assign in_index  = in_tdata[txcw_pkg::CHAR_W +: txcw_pkg::INDEX_W];
  assign index_ext = CMPW'(in_index);

  assign pos          = CNTW'(row_r) * CNTW'(COLS) + CNTW'(col_r);
  assign pos_ext      = PXW'(pos);
  assign cur_addr     = AW'(row_r) * AW'(COLS) + AW'(col_r);
  assign scroll_raddr = cnt_r + CNTW'(COLS);
  assign at_last_row  = (row_r == RW'(ROWS - 1));
  assign out_free     = !out_tvalid_r || out_tready;

  assign in_tready  = (state_r == txcw_pkg::ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  txcw_ram #(
    .WIDTH (txcw_pkg::CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    char_nxt       = char_r;
    rd_ok_nxt      = rd_ok_r;
    value_nxt      = value_r;
    out_tdata_nxt  = out_tdata_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    mem_we         = 1'b0;
    mem_waddr      = cur_addr;
    mem_wdata      = '0;
    mem_raddr      = index_ext[AW-1:0];

    case (state_r)
      txcw_pkg::ST_INIT, txcw_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r[AW-1:0];
        cnt_nxt   = cnt_r + CNTW'(1);
        if (cnt_r == CNTW'(CELLS - 1)) begin
          state_nxt = (state_r == txcw_pkg::ST_INIT) ? txcw_pkg::ST_IDLE
                                                     : txcw_pkg::ST_EMIT;
        end
      end
      txcw_pkg::ST_IDLE: begin
        value_nxt = '0;
        if (in_tvalid) begin
          char_nxt = in_char;
          case (txcw_pkg::action_t'(in_tuser))
            txcw_pkg::ACT_PUT: begin
              state_nxt = txcw_pkg::ST_PUT;
            end
            txcw_pkg::ACT_READ: begin
              rd_ok_nxt = (index_ext < CMPW'(CELLS));
              state_nxt = txcw_pkg::ST_READ;
            end
            txcw_pkg::ACT_CLEAR: begin
              cnt_nxt   = '0;
              state_nxt = txcw_pkg::ST_CLEAR;
            end
            default: begin
              state_nxt = txcw_pkg::ST_EMIT;
            end
          endcase
        end
      end
      txcw_pkg::ST_PUT: begin
        if (char_r == txcw_pkg::NEWLINE_CODE || col_r == CLW'(COLS)) begin
          col_nxt = '0;
          if (at_last_row) begin
            cnt_nxt   = '0;
            state_nxt = txcw_pkg::ST_SCROLL;
          end else begin
            row_nxt   = row_r + RW'(1);
            state_nxt = (char_r == txcw_pkg::NEWLINE_CODE) ? txcw_pkg::ST_EMIT
                                                           : txcw_pkg::ST_PUT;
          end
        end else begin
          mem_we    = 1'b1;
          mem_wdata = {attr_r, char_r};
          col_nxt   = col_r + CLW'(1);
          state_nxt = txcw_pkg::ST_EMIT;
        end
      end
      txcw_pkg::ST_READ: begin
        value_nxt = rd_ok_r ? mem_rdata : '0;
        state_nxt = txcw_pkg::ST_EMIT;
      end
      txcw_pkg::ST_SCROLL: begin
        // read one row ahead, write the cell read in the previous cycle
        mem_raddr = scroll_raddr[AW-1:0];
        cnt_nxt   = cnt_r + CNTW'(1);
        if (cnt_r != '0) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(cnt_r - CNTW'(1));
          mem_wdata = (cnt_r <= CNTW'(MOVE)) ? mem_rdata : '0;
        end
        if (cnt_r == CNTW'(CELLS)) begin
          state_nxt = (char_r == txcw_pkg::NEWLINE_CODE) ? txcw_pkg::ST_EMIT
                                                         : txcw_pkg::ST_PUT;
        end
      end
      txcw_pkg::ST_EMIT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {{PADW{1'b0}}, pos_ext[txcw_pkg::POS_W-1:0], value_r};
          state_nxt      = txcw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = txcw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= txcw_pkg::ST_INIT;
      cnt_r        <= '0;
      row_r        <= '0;
      col_r        <= '0;
      attr_r       <= txcw_pkg::ATTR_RESET;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wr_en) begin
        attr_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    char_r      <= char_nxt;
    rd_ok_r     <= rd_ok_nxt;
    value_r     <= value_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

endmodule
`default_nettype wire
